// ===== rtl/pwmicm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pwmicm_pkg;

  // Timestamp and result widths
  localparam int unsigned CntBits   = 16;
  localparam int unsigned TickBits  = 27;
  localparam int unsigned DutyBits  = 7;

  // Dividend carries tick_hz plus half a period, one bit wider than tick_hz
  localparam int unsigned DivBits   = TickBits + 1;
  localparam int unsigned StepBits  = $clog2(DivBits);

  localparam int unsigned ScaleBits = 7;
  localparam int unsigned ProdBits  = CntBits + ScaleBits;

  localparam logic [TickBits-1:0]  TickHzReset = TickBits'(1000000);
  localparam logic [ScaleBits-1:0] DutyScale   = ScaleBits'(100);
  localparam logic [DutyBits-1:0]  DutyMax     = DutyBits'(100);

  typedef logic [CntBits-1:0]  cnt_t;
  typedef logic [TickBits-1:0] tick_t;
  typedef logic [DutyBits-1:0] duty_t;
  typedef logic [DivBits-1:0]  div_t;
  typedef logic [StepBits-1:0] step_t;

  typedef enum logic [1:0] {
    PH_FIRST_RISE = 2'd0,
    PH_FALL       = 2'd1,
    PH_NEXT_RISE  = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    ST_IDLE     = 2'd0,
    ST_DIV_FREQ = 2'd1,
    ST_DIV_DUTY = 2'd2,
    ST_OUT      = 2'd3
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/pwm_input_capture_measure.sv =====
`timescale 1ns / 1ps
`default_nettype none

// PWM input-capture measurement.
// Input channel (capture_time_i, in_valid_i / in_stall_o): one timestamp of the
// free-running capture counter per request, in order first rise, fall, next rise.
// Output channel (period/high/frequency/duty, out_valid_o / out_stall_i): one
// result per next-rise request with a nonzero period.
// Config channel (cfg_tick_hz_i, cfg_valid_i / cfg_ready_o): counter tick rate,
// always ready; write only while the block is idle.
// Sequence: a rise or fall request without result is taken in idle and needs no
// further steps. A result request is taken, then one shared restoring divider
// (one compare-subtract per cycle over a 28-bit dividend) runs the frequency
// division and then the duty division, and then the output register is loaded.
// in_stall_o is high in the divide and output-load states, and out_valid_o
// rises when the output register is loaded.
// The result sits in an output register; a new request is taken while it
// waits. If a stalled result is still unread when the next one is done, the
// block holds in its output state until the receiver takes the old one.
// Reset: waits for a first rising edge, tick rate 1 MHz, no result pending.
module pwm_input_capture_measure
  import pwmicm_pkg::*;
(
  input  wire                 clk_i,
  input  wire                 rst_ni,
  // capture requests
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  wire  [CntBits-1:0]  capture_time_i,
  // measurement results
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output logic [CntBits-1:0]  period_count_o,
  output logic [CntBits-1:0]  high_count_o,
  output logic [TickBits-1:0] frequency_hz_o,
  output logic [DutyBits-1:0] duty_percent_o,
  // tick rate register
  input  wire                 cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire  [TickBits-1:0] cfg_tick_hz_i
);

  state_e state_q, state_d;
  phase_e phase_q, phase_d;

  tick_t  tick_hz_q;
  cnt_t   last_rise_q, last_rise_d;
  cnt_t   high_time_q, high_time_d;
  cnt_t   period_q,    period_d;

  // shared divider: remainder, dividend/quotient shift register, step count
  cnt_t   rem_q, rem_d;
  div_t   quo_q, quo_d;
  step_t  step_q, step_d;

  tick_t  freq_q, freq_d;
  duty_t  duty_q, duty_d;

  logic   out_valid_q, out_valid_d;
  cnt_t   out_period_q, out_high_q;
  tick_t  out_freq_q;
  duty_t  out_duty_q;

  logic   in_req;
  logic   out_take;
  logic   out_free;
  logic   out_load;
  logic   div_last;
  cnt_t   diff_t;
  logic   [CntBits:0]  div_trial;
  logic   [CntBits:0]  div_diff;
  logic   div_ge;
  cnt_t   rem_next;
  div_t   quo_next;
  logic   [ProdBits-1:0] high_scaled;
  div_t   freq_dividend;
  div_t   duty_dividend;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_req      = in_valid_i && !in_stall_o;
  assign out_take    = out_valid_q && !out_stall_i;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_load    = (state_q == ST_OUT) && out_free;
  assign div_last    = (step_q == '0);

  // wrapped timestamp difference against the last rising edge
  assign diff_t = capture_time_i - last_rise_q;

  // one restoring step: bring in the next dividend bit, compare, subtract
  assign div_trial = {rem_q, quo_q[DivBits-1]};
  assign div_diff  = div_trial - {1'b0, period_q};
  assign div_ge    = (div_trial >= {1'b0, period_q});
  assign rem_next  = div_ge ? div_diff[CntBits-1:0] : div_trial[CntBits-1:0];
  assign quo_next  = {quo_q[DivBits-2:0], div_ge};

  // rounding: add half the divisor before dividing
  assign freq_dividend = {1'b0, tick_hz_q} + div_t'(diff_t >> 1);
  assign high_scaled   = high_time_q * DutyScale;
  assign duty_dividend = div_t'(high_scaled) + div_t'(period_q >> 1);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_req && (phase_q == PH_NEXT_RISE) && (diff_t != '0)) begin
          state_d = ST_DIV_FREQ;
        end
      end
      ST_DIV_FREQ: begin
        if (div_last) begin
          state_d = ST_DIV_DUTY;
        end
      end
      ST_DIV_DUTY: begin
        if (div_last) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // phase tracking, divider and result datapath
  always_comb begin
    phase_d     = phase_q;
    last_rise_d = last_rise_q;
    high_time_d = high_time_q;
    period_d    = period_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    step_d      = step_q;
    freq_d      = freq_q;
    duty_d      = duty_q;
    case (state_q)
      ST_IDLE: begin
        if (in_req) begin
          case (phase_q)
            PH_FALL: begin
              high_time_d = diff_t;
              phase_d     = PH_NEXT_RISE;
            end
            PH_NEXT_RISE: begin
              last_rise_d = capture_time_i;
              phase_d     = PH_FALL;
              period_d    = diff_t;
              rem_d       = '0;
              quo_d       = freq_dividend;
              step_d      = step_t'(DivBits - 1);
            end
            default: begin
              // first rise, and the unused phase code
              last_rise_d = capture_time_i;
              phase_d     = PH_FALL;
            end
          endcase
        end
      end
      ST_DIV_FREQ: begin
        step_d = step_q - step_t'(1);
        rem_d  = rem_next;
        quo_d  = quo_next;
        if (div_last) begin
          freq_d = quo_next[TickBits-1:0];
          rem_d  = '0;
          quo_d  = duty_dividend;
          step_d = step_t'(DivBits - 1);
        end
      end
      ST_DIV_DUTY: begin
        step_d = step_q - step_t'(1);
        rem_d  = rem_next;
        quo_d  = quo_next;
        if (div_last) begin
          // saturate at full duty
          duty_d = (quo_next > div_t'(DutyMax)) ? DutyMax : quo_next[DutyBits-1:0];
        end
      end
      ST_OUT: begin
      end
      default: begin
      end
    endcase
  end

  // output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_take) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_FIRST_RISE;
      tick_hz_q   <= TickHzReset;
      last_rise_q <= '0;
      high_time_q <= '0;
      out_valid_q <= 1'b0;
      step_q      <= '0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      last_rise_q <= last_rise_d;
      high_time_q <= high_time_d;
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
      if (cfg_valid_i && cfg_ready_o) begin
        tick_hz_q <= cfg_tick_hz_i;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    period_q <= period_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    freq_q   <= freq_d;
    duty_q   <= duty_d;
    if (out_load) begin
      out_period_q <= period_q;
      out_high_q   <= high_time_q;
      out_freq_q   <= freq_q;
      out_duty_q   <= duty_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign period_count_o = out_period_q;
  assign high_count_o   = out_high_q;
  assign frequency_hz_o = out_freq_q;
  assign duty_percent_o = out_duty_q;

endmodule

`default_nettype wire
